[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge, masked during reset
`define PPT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// combinational relation checked at every clock edge, also during reset
`define PPT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/ppt_pkg.sv]
// constants, types and reciprocal seed table for the perspective point transform
// no dependencies
package ppt_pkg;

    typedef logic signed [15:0] coef_t;
    typedef logic [2:0]         reg_idx_t;

    localparam int unsigned PIPE_DEPTH = 11;

    localparam reg_idx_t REG_ROT_ROW0  = 3'd0;
    localparam reg_idx_t REG_ROT_ROW1  = 3'd1;
    localparam reg_idx_t REG_ROT_ROW2  = 3'd2;
    localparam reg_idx_t REG_NEG_EYE_X = 3'd3;
    localparam reg_idx_t REG_NEG_EYE_Y = 3'd4;
    localparam reg_idx_t REG_NEG_EYE_Z = 3'd5;
    localparam reg_idx_t REG_PROJ_DIST = 3'd6;
    localparam reg_idx_t REG_SCREEN_OF = 3'd7;

    localparam logic [16:0] Q_SAT      = 17'h1FFFF;
    localparam logic [15:0] NORM_BIT   = 16'h8000;
    localparam logic [39:0] NEWTON_A   = 40'h2000080;
    localparam logic [42:0] NEWTON_B   = 43'h0000080;
    localparam logic [15:0] IDX_BASE   = 16'h7FC0;
    localparam logic [18:0] SEED_NUM   = 19'h40000;
    localparam logic [9:0]  SEED_BIAS  = 10'h101;
    localparam logic [8:0]  IDX_MAX    = 9'h100;
    localparam logic [63:0] ROUND_HALF = 64'h8000;
    localparam int          SCR_MIN    = -1024;
    localparam int          SCR_MAX    = 1023;
    localparam int          DEPTH_MAX  = 65535;
    localparam int          SEED_CNT   = 257;

    // seed entry i: round(0x40000 / (i + 0x100) / 2) - 0x101, floored at 0
    function automatic logic [SEED_CNT*8-1:0] build_seed_table();
        logic [SEED_CNT*8-1:0] tab;
        logic [19:0]           rem;
        logic [18:0]           quo;
        logic [19:0]           den;
        int                    e;
        tab = '0;
        for (int i = 0; i < SEED_CNT; i++) begin
            den = 20'(i + 256);
            rem = '0;
            quo = '0;
            for (int b = 18; b >= 0; b--) begin
                rem = {rem[18:0], SEED_NUM[b]};
                if (rem >= den) begin
                    rem    = rem - den;
                    quo[b] = 1'b1;
                end
            end
            e = int'((20'(quo) + 20'd1) >> 1) - 257;
            tab[i*8 +: 8] = (e < 0) ? 8'd0 : 8'(e);
        end
        return tab;
    endfunction

    localparam logic [SEED_CNT*8-1:0] SEED_TABLE = build_seed_table();

endpackage

[hw/rtl/perspective_point_transform.sv]
// perspective point transform, top level and full datapath
// depends on ppt_pkg and assert_macros.svh
//
// Projects one signed 32-bit world point per beat onto a clamped 11-bit screen
// position and a 16-bit depth key. The block is an 11-stage pipeline: a point
// may enter on every cycle in which the pipe does not stall, so the sustained
// rate is one beat per cycle while m_tready stays high. The whole pipeline advances together;
// it stalls only while a result waits on m_tready, and s_tready is then low.
// Stages: eye offset, shift normalize, nine 16x16 products, row sums and
// saturation, divisor normalize and seed lookup, two newton steps, a 32x32
// quotient product, rounding, screen products, offset and clamp.
// Configuration goes through a 64-bit apb port, register i at byte 8*i, and
// must only be written while no point is in flight.
`include "assert_macros.svh"

module perspective_point_transform (
    input  logic        aclk,
    input  logic        aresetn,
    // input point stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // world_x, world_y, world_z (32 bits each)
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // screen_x (11), screen_y (11), depth_key (16), zero pad
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // ---------------- configuration registers ----------------
    logic [47:0] rot_row0_reg, rot_row1_reg, rot_row2_reg;
    logic [31:0] neg_eye_x_reg, neg_eye_y_reg, neg_eye_z_reg;
    logic [15:0] proj_dist_reg;
    logic [63:0] screen_of_reg;
    logic        cfg_wr;
    ppt_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_row0_reg  <= '0;
            rot_row1_reg  <= '0;
            rot_row2_reg  <= '0;
            neg_eye_x_reg <= '0;
            neg_eye_y_reg <= '0;
            neg_eye_z_reg <= '0;
            proj_dist_reg <= '0;
            screen_of_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                ppt_pkg::REG_ROT_ROW0:  rot_row0_reg  <= pwdata[47:0];
                ppt_pkg::REG_ROT_ROW1:  rot_row1_reg  <= pwdata[47:0];
                ppt_pkg::REG_ROT_ROW2:  rot_row2_reg  <= pwdata[47:0];
                ppt_pkg::REG_NEG_EYE_X: neg_eye_x_reg <= pwdata[31:0];
                ppt_pkg::REG_NEG_EYE_Y: neg_eye_y_reg <= pwdata[31:0];
                ppt_pkg::REG_NEG_EYE_Z: neg_eye_z_reg <= pwdata[31:0];
                ppt_pkg::REG_PROJ_DIST: proj_dist_reg <= pwdata[15:0];
                ppt_pkg::REG_SCREEN_OF: screen_of_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // register read mux
    always_comb begin
        unique case (cfg_idx)
            ppt_pkg::REG_ROT_ROW0:  prdata = {16'd0, rot_row0_reg};
            ppt_pkg::REG_ROT_ROW1:  prdata = {16'd0, rot_row1_reg};
            ppt_pkg::REG_ROT_ROW2:  prdata = {16'd0, rot_row2_reg};
            ppt_pkg::REG_NEG_EYE_X: prdata = {32'd0, neg_eye_x_reg};
            ppt_pkg::REG_NEG_EYE_Y: prdata = {32'd0, neg_eye_y_reg};
            ppt_pkg::REG_NEG_EYE_Z: prdata = {32'd0, neg_eye_z_reg};
            ppt_pkg::REG_PROJ_DIST: prdata = {48'd0, proj_dist_reg};
            ppt_pkg::REG_SCREEN_OF: prdata = screen_of_reg;
            default:                prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // one enable for every stage: the pipe moves unless the output beat is stuck
    logic                            pipe_en;
    logic [ppt_pkg::PIPE_DEPTH-1:0]  valid_reg;

    assign pipe_en  = !valid_reg[ppt_pkg::PIPE_DEPTH-1] || m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = valid_reg[ppt_pkg::PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[ppt_pkg::PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // ---------------- stage 1: eye offset, magnitude or ----------------
    logic [31:0] pos_next [3];
    logic [31:0] pos_reg  [3];
    logic [31:0] mag_next, mag_reg;

    always_comb begin
        pos_next[0] = s_tdata[31:0]  + neg_eye_x_reg;
        pos_next[1] = s_tdata[63:32] + neg_eye_y_reg;
        pos_next[2] = s_tdata[95:64] + neg_eye_z_reg;
        mag_next = '0;
        for (int i = 0; i < 3; i++) begin
            mag_next = mag_next | (pos_next[i][31] ? (32'd0 - pos_next[i]) : pos_next[i]);
        end
    end

    // ---------------- stage 2: shift normalize ----------------
    logic [5:0]  blen;
    logic [4:0]  scale_next;
    logic signed [15:0] vec_next [3];
    logic signed [15:0] vec_reg  [3];
    logic [4:0]  scale2_reg;

    always_comb begin
        blen = '0;
        for (int b = 0; b < 32; b++) begin
            if (mag_reg[b]) blen = 6'(b + 1);
        end
        scale_next = (blen > 6'd13) ? 5'(blen - 6'd13) : 5'd0;
        for (int i = 0; i < 3; i++) begin
            vec_next[i] = 16'($signed(pos_reg[i]) >>> scale_next);
        end
    end

    // ---------------- stage 3: nine products ----------------
    logic signed [31:0] prod_next [9];
    logic signed [31:0] prod_reg  [9];
    logic [4:0]         scale3_reg;
    ppt_pkg::coef_t     rot_coef  [9];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rot_coef[k]     = ppt_pkg::coef_t'(rot_row0_reg[16*k +: 16]);
            rot_coef[3 + k] = ppt_pkg::coef_t'(rot_row1_reg[16*k +: 16]);
            rot_coef[6 + k] = ppt_pkg::coef_t'(rot_row2_reg[16*k +: 16]);
        end
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                prod_next[3*r + k] = rot_coef[3*r + k] * vec_reg[k];
            end
        end
    end

    // ---------------- stage 4: row sums, floor shift, saturation ----------------
    logic signed [33:0] row_sum [3];
    logic signed [21:0] row_acc [3];
    logic signed [15:0] rr_next [3];
    logic [15:0]        dep_next;
    logic signed [15:0] rr4_reg [3];
    logic [15:0]        dep4_reg;
    logic [4:0]         scale4_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row_sum[r] = 34'(prod_reg[3*r]) + 34'(prod_reg[3*r + 1]) + 34'(prod_reg[3*r + 2]);
            row_acc[r] = 22'(row_sum[r] >>> 12);
            if (row_acc[r] < -22'sd32768) begin
                rr_next[r] = -16'sd32768;
            end else if (row_acc[r] > 22'sd32767) begin
                rr_next[r] = 16'sd32767;
            end else begin
                rr_next[r] = 16'(row_acc[r]);
            end
        end
        if (row_acc[2] < 22'sd0) begin
            dep_next = '0;
        end else if (row_acc[2] > 22'(ppt_pkg::DEPTH_MAX)) begin
            dep_next = 16'(ppt_pkg::DEPTH_MAX);
        end else begin
            dep_next = 16'(row_acc[2]);
        end
    end

    // ---------------- stage 5: divisor normalize, seed lookup, depth key ----------------
    logic        sat_next;
    logic [3:0]  lz;
    logic [15:0] dn_next;
    logic [31:0] nn_next;
    logic [15:0] idx_raw;
    logic [8:0]  idx;
    logic [9:0]  uu_next;
    logic [31:0] zw;
    logic [15:0] zk_next;

    always_comb begin
        sat_next = !({1'b0, proj_dist_reg} < {dep4_reg, 1'b0});
        lz = '0;
        for (int b = 0; b < 16; b++) begin
            if (dep4_reg[b]) lz = 4'(15 - b);
        end
        dn_next = dep4_reg << lz;
        nn_next = 32'(proj_dist_reg) << lz;
        idx_raw = (dn_next - ppt_pkg::IDX_BASE) >> 7;
        idx     = (idx_raw > 16'(ppt_pkg::IDX_MAX)) ? ppt_pkg::IDX_MAX : idx_raw[8:0];
        uu_next = 10'(ppt_pkg::SEED_TABLE[idx*8 +: 8]) + ppt_pkg::SEED_BIAS;
        zw      = 32'(rr4_reg[2]) << scale4_reg;
        zk_next = zw[28:13];
    end

    logic               sat_reg   [5:9];
    logic signed [15:0] rx_reg    [5:9];
    logic signed [15:0] ry_reg    [5:9];
    logic [15:0]        zk_reg    [5:10];
    logic [31:0]        nn_reg    [5:7];
    logic [9:0]         uu_reg    [5:6];
    logic [15:0]        dn5_reg;

    // ---------------- stage 6 and 7: newton steps ----------------
    logic [39:0] nt1_full;
    logic [31:0] t1_next, t1_reg;
    logic [42:0] nt2_full;
    logic [31:0] t2_next, t2_reg;

    assign nt1_full = ppt_pkg::NEWTON_A - 40'(dn5_reg) * 40'(uu_reg[5]);
    assign t1_next  = nt1_full[39:8];
    assign nt2_full = ppt_pkg::NEWTON_B + 43'(t1_reg) * 43'(uu_reg[6]);
    assign t2_next  = nt2_full[39:8];

    // ---------------- stage 8 and 9: quotient product and rounding ----------------
    logic [63:0] qprod_next, qprod_reg;
    logic [63:0] qround;
    logic [16:0] q_next, q_reg;

    assign qprod_next = 64'(nn_reg[7]) * 64'(t2_reg);
    always_comb begin
        qround = qprod_reg + ppt_pkg::ROUND_HALF;
        if (sat_reg[8] || (qround[63:16] > 48'(ppt_pkg::Q_SAT))) begin
            q_next = ppt_pkg::Q_SAT;
        end else begin
            q_next = qround[32:16];
        end
    end

    // ---------------- stage 10: screen products ----------------
    logic signed [33:0] px_next, py_next, px_reg, py_reg;

    assign px_next = $signed({1'b0, q_reg}) * rx_reg[9];
    assign py_next = $signed({1'b0, q_reg}) * ry_reg[9];

    // ---------------- stage 11: offset, shift, clamp ----------------
    logic signed [34:0] sx_sum, sy_sum;
    logic signed [18:0] sx_sh, sy_sh;
    logic signed [10:0] sx_next, sy_next;
    logic [39:0]        out_reg;

    always_comb begin
        sx_sum = 35'(px_reg) + 35'($signed(screen_of_reg[63:32]));
        sy_sum = 35'(py_reg) + 35'($signed(screen_of_reg[31:0]));
        sx_sh  = 19'(sx_sum >>> 16);
        sy_sh  = 19'(sy_sum >>> 16);
        if (sx_sh < 19'(ppt_pkg::SCR_MIN))      sx_next = 11'(ppt_pkg::SCR_MIN);
        else if (sx_sh > 19'(ppt_pkg::SCR_MAX)) sx_next = 11'(ppt_pkg::SCR_MAX);
        else                                    sx_next = 11'(sx_sh);
        if (sy_sh < 19'(ppt_pkg::SCR_MIN))      sy_next = 11'(ppt_pkg::SCR_MIN);
        else if (sy_sh > 19'(ppt_pkg::SCR_MAX)) sy_next = 11'(ppt_pkg::SCR_MAX);
        else                                    sy_next = 11'(sy_sh);
    end

    assign m_tdata = out_reg;

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            // stage 1
            pos_reg    <= pos_next;
            mag_reg    <= mag_next;
            // stage 2
            vec_reg    <= vec_next;
            scale2_reg <= scale_next;
            // stage 3
            prod_reg   <= prod_next;
            scale3_reg <= scale2_reg;
            // stage 4
            rr4_reg    <= rr_next;
            dep4_reg   <= dep_next;
            scale4_reg <= scale3_reg;
            // stage 5
            sat_reg[5] <= sat_next;
            rx_reg[5]  <= rr4_reg[0];
            ry_reg[5]  <= rr4_reg[1];
            zk_reg[5]  <= zk_next;
            nn_reg[5]  <= nn_next;
            uu_reg[5]  <= uu_next;
            dn5_reg    <= dn_next;
            // stage 6
            t1_reg     <= t1_next;
            uu_reg[6]  <= uu_reg[5];
            nn_reg[6]  <= nn_reg[5];
            // stage 7
            t2_reg     <= t2_next;
            nn_reg[7]  <= nn_reg[6];
            // stage 8
            qprod_reg  <= qprod_next;
            for (int s = 6; s <= 9; s++) begin
                sat_reg[s] <= sat_reg[s-1];
                rx_reg[s]  <= rx_reg[s-1];
                ry_reg[s]  <= ry_reg[s-1];
            end
            for (int s = 6; s <= 10; s++) begin
                zk_reg[s] <= zk_reg[s-1];
            end
            // stage 9
            q_reg      <= q_next;
            // stage 10
            px_reg     <= px_next;
            py_reg     <= py_next;
            // stage 11
            out_reg    <= {2'b00, zk_reg[10], sy_next, sx_next};
        end
    end

    // ---------------- checks ----------------
    `PPT_ASSERT(a_ready_follows_stall, aclk, aresetn, s_tready == (!m_tvalid || m_tready),
        "input ready does not match output stall")
    `PPT_ASSERT(a_valid_advances, aclk, aresetn,
        pipe_en && valid_reg[4] |=> valid_reg[5], "valid bit lost between stages")
    `PPT_ASSERT(a_sat_gives_max, aclk, aresetn,
        pipe_en && sat_reg[8] |=> q_reg == ppt_pkg::Q_SAT,
        "saturated divide did not give the maximum quotient")
    `PPT_ASSERT(a_stall_freezes_pipe, aclk, aresetn,
        !pipe_en |=> $stable(valid_reg), "valid bits moved during a stall")

endmodule

[test/perspective_point_transform_test.sv]
// testbench for the perspective point transform: directed and random points,
// apb register settings, random stalls on both streams
// depends on ppt_pkg and the perspective_point_transform rtl
module perspective_point_transform_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [10:0] sx;
        logic signed [10:0] sy;
        logic signed [15:0] zk;
    } proj_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;   // world_x, world_y, world_z
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // screen_x, screen_y, depth_key, zero pad
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    perspective_point_transform DUT (.*);

    always #5 aclk = ~aclk;

    // shadow copy of the register file
    logic [47:0]        rot [3];
    logic signed [31:0] eye [3];
    logic [15:0]        hdist;
    logic [63:0]        offs;

    proj_t projections [$];
    int    failures = 0;
    bit    calm = 0;       // no idling in the last part
    int    hold_cycles = 0; // long receiver hold-off request

    // reciprocal seed from its closed form
    function automatic logic [31:0] seed_of(logic [31:0] idx);
        int e;
        e = int'((32'h40000 / (idx + 32'h100) + 1) / 2) - 257;
        return e < 0 ? 32'd0 : 32'(e);
    endfunction

    function automatic logic [31:0] divide_hw(logic [31:0] h, logic [31:0] d);
        int unsigned lz;
        logic [63:0] nn, t, qq;
        logic [31:0] dn, uu, idx;
        if (!(h < d * 2)) return 32'h1FFFF;
        lz = 0;
        while (lz < 16 && (((d << lz) & 32'h8000) == 0)) lz++;
        nn  = 64'(h) << lz;
        dn  = (d << lz) & 32'hFFFF;
        idx = (dn - 32'h7FC0) >> 7;
        if (idx > 32'h100) idx = 32'h100;
        uu = seed_of(idx) + 32'h101;
        t  = (64'h2000080 - 64'(dn) * 64'(uu)) >> 8;
        dn = t[31:0];
        t  = (64'h80 + 64'(dn) * 64'(uu)) >> 8;
        dn = t[31:0];
        qq = (nn * 64'(dn) + 64'h8000) >> 16;
        return qq > 64'h1FFFF ? 32'h1FFFF : qq[31:0];
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic proj_t project_point(logic [95:0] pt);
        logic [31:0] sum [3];
        logic [31:0] mag;
        longint      vec [3], acc [3], rr [3], s, q, dep;
        int          bits, sc;
        logic [31:0] zw;
        proj_t       r;
        mag = 0;
        for (int i = 0; i < 3; i++) begin
            sum[i] = pt[32*i +: 32] + eye[i];
            mag |= sum[i][31] ? -sum[i] : sum[i];
        end
        bits = 0;
        while (bits < 32 && (mag >> bits) != 0) bits++;
        sc = bits > 13 ? bits - 13 : 0;
        for (int i = 0; i < 3; i++)
            vec[i] = longint'($signed(16'(longint'($signed(sum[i])) >>> sc)));
        for (int i = 0; i < 3; i++) begin
            s = 0;
            for (int k = 0; k < 3; k++)
                s += longint'($signed(rot[i][16*k +: 16])) * vec[k];
            acc[i] = s >>> 12;
            rr[i]  = clampl(acc[i], -32768, 32767);
        end
        dep = clampl(acc[2], 0, 65535);
        q   = longint'(divide_hw(32'(hdist), 32'(dep)));
        r.sx = 11'(clampl((q * rr[0] + longint'($signed(offs[63:32]))) >>> 16, -1024, 1023));
        r.sy = 11'(clampl((q * rr[1] + longint'($signed(offs[31:0]))) >>> 16, -1024, 1023));
        zw   = 32'(rr[2] << sc);
        r.zk = 16'($signed(zw) >>> 13);
        return r;
    endfunction

    task automatic idle_gap();
        if (!calm && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 8)) @(negedge aclk);
    endtask

    task automatic write_reg(ppt_pkg::reg_idx_t idx, logic [63:0] val);
        @(negedge aclk);
        psel = 1; pwrite = 1; paddr = {idx, 3'b000}; pwdata = val; penable = 0;
        @(negedge aclk);
        penable = 1;
        @(posedge aclk);
        @(negedge aclk);
        psel = 0; penable = 0; pwrite = 0;
        case (idx)
            ppt_pkg::REG_ROT_ROW0:  rot[0] = val[47:0];
            ppt_pkg::REG_ROT_ROW1:  rot[1] = val[47:0];
            ppt_pkg::REG_ROT_ROW2:  rot[2] = val[47:0];
            ppt_pkg::REG_NEG_EYE_X: eye[0] = val[31:0];
            ppt_pkg::REG_NEG_EYE_Y: eye[1] = val[31:0];
            ppt_pkg::REG_NEG_EYE_Z: eye[2] = val[31:0];
            ppt_pkg::REG_PROJ_DIST: hdist  = val[15:0];
            ppt_pkg::REG_SCREEN_OF: offs   = val;
            default: ;
        endcase
    endtask

    // one point beat; expectation queued at acceptance
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        idle_gap();
        s_tvalid = 1; s_tdata = {z, y, x};
        do @(posedge aclk); while (!s_tready);
        projections = {projections, project_point(s_tdata)};
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic drain();
        while (projections.size() != 0) @(negedge aclk);
        repeat (ppt_pkg::PIPE_DEPTH + 4) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 16383)) - 8192);
            2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return 32'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        return $urandom_range(0, 1) ? 16'($signed($urandom_range(0, 8192)) - 4096)
                                    : 16'($urandom);
    endfunction

    task automatic random_setting(bit extreme);
        for (int i = 0; i < 3; i++)
            write_reg(ppt_pkg::reg_idx_t'(i), {16'h0, rand_coef(), rand_coef(), rand_coef()});
        write_reg(ppt_pkg::REG_NEG_EYE_X, extreme ? 64'h8000_0000 : 64'(rand_coord()));
        write_reg(ppt_pkg::REG_NEG_EYE_Y, extreme ? 64'h7FFF_FFFF : 64'(rand_coord()));
        write_reg(ppt_pkg::REG_NEG_EYE_Z, 64'(rand_coord()));
        write_reg(ppt_pkg::REG_PROJ_DIST,
                  extreme ? 64'hFFFF : 64'($urandom_range(0, 65535)));
        write_reg(ppt_pkg::REG_SCREEN_OF, {$urandom, $urandom});
    endtask

    task automatic test_identity_directed();
        // identity rotation, modest distance: exercises quotient paths
        write_reg(ppt_pkg::REG_ROT_ROW0, 64'h0000_0000_0000_1000);
        write_reg(ppt_pkg::REG_ROT_ROW1, 64'h0000_0000_1000_0000);
        write_reg(ppt_pkg::REG_ROT_ROW2, 64'h0000_1000_0000_0000);
        write_reg(ppt_pkg::REG_PROJ_DIST, 64'd200);
        write_reg(ppt_pkg::REG_SCREEN_OF, 64'h0140_0000_00F0_0000);
        send_point(0, 0, 0);                   // zero depth saturates quotient
        send_point(10, -10, 50);               // far: h >= 2*depth
        send_point(100, 50, 1000);
        send_point(8000, -8000, 150);          // screen position overflows and clamps
        send_point(5, 5, -300);                // negative depth
        send_point(32'h8000_0000, 0, 4000);    // most negative coordinate
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_point(4095, 4096, 8191);
        send_point(8192, -8193, 16384);
        drain();
        // extremes of every register
        write_reg(ppt_pkg::REG_ROT_ROW0, 64'h0000_7FFF_8000_7FFF);
        write_reg(ppt_pkg::REG_ROT_ROW1, 64'h0000_8000_7FFF_8000);
        write_reg(ppt_pkg::REG_ROT_ROW2, 64'h0000_7FFF_7FFF_7FFF);
        write_reg(ppt_pkg::REG_NEG_EYE_X, 64'h8000_0000);
        write_reg(ppt_pkg::REG_NEG_EYE_Y, 64'h7FFF_FFFF);
        write_reg(ppt_pkg::REG_NEG_EYE_Z, 64'hFFFF_FFFF);
        write_reg(ppt_pkg::REG_PROJ_DIST, 64'hFFFF);
        write_reg(ppt_pkg::REG_SCREEN_OF, 64'h7FFF_FFFF_8000_0000);
        send_point(0, 0, 0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 1, 32'h8000_0001);
        send_point(1, 1, 1);
        send_point(-1, -1, -1);
        drain();
    endtask

    task automatic test_random_points(int n, bit extreme);
        random_setting(extreme);
        for (int i = 0; i < n; i++)
            send_point(rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic test_backpressure();
        // receiver holds off while points keep coming, pipeline fills
        hold_cycles = 60;
        for (int i = 0; i < 40; i++)
            send_point(rand_coord(), rand_coord(), rand_coord());
        drain();
        // sender pauses for all results, then resumes
        for (int i = 0; i < 20; i++)
            send_point(rand_coord(), rand_coord(), rand_coord());
        while (projections.size() != 0) @(negedge aclk);
        for (int i = 0; i < 20; i++)
            send_point(rand_coord(), rand_coord(), rand_coord());
        drain();
    endtask

    // receiver: random stalls and the long hold-off
    always @(negedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else
            m_tready <= calm ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    // result checker
    always @(posedge aclk) begin
        proj_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = proj_t'({m_tdata[10:0], m_tdata[21:11], m_tdata[37:22]});
            if (projections.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $realtime, m_tdata);
                failures++;
            end else begin
                want = projections.pop_front();
                if (got.sx !== want.sx) begin
                    $display("%0t: screen_x expected %0d actual %0d", $realtime, want.sx, got.sx);
                    failures++;
                end
                if (got.sy !== want.sy) begin
                    $display("%0t: screen_y expected %0d actual %0d", $realtime, want.sy, got.sy);
                    failures++;
                end
                if (got.zk !== want.zk) begin
                    $display("%0t: depth_key expected %0d actual %0d", $realtime, want.zk, got.zk);
                    failures++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < 3; i++) begin rot[i] = 0; eye[i] = 0; end
        hdist = 0; offs = 0;
        repeat (3) @(negedge aclk);
        aresetn = 1;
        test_identity_directed();
        for (int k = 0; k < 5; k++) begin
            test_random_points(110, k == 2);
            drain();
        end
        test_backpressure();
        calm = 1;
        test_random_points(100, 0);
        drain();
        if (failures == 0)
            $display("** perspective_point_transform: PASSED **");
        else
            $display("** perspective_point_transform: FAILED **");
        $finish;
    end

    initial begin
        #2ms;
        $display("** perspective_point_transform: FAILED **");
        $finish;
    end
endmodule
